>>> design/dwpi_pkg.sv
// Shared types, register codes and fixed-point constants for the dual wheel
// PI controller. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dwpi_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_PER_TICK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP        = 3'd4;

    localparam logic [15:0] RST_PROP_GAIN      = 16'd1024;
    localparam logic [15:0] RST_INTEG_GAIN     = 16'd128;
    localparam logic [15:0] RST_FF_GAIN        = 16'd741;
    localparam logic [15:0] RST_SPEED_PER_TICK = 16'd26396;
    localparam logic [15:0] RST_PWM_TOP        = 16'd999;

    // +-100 percent, in Q8.8 and whole
    localparam logic signed [15:0] PCT_LIMIT_Q = 16'sd25600;
    localparam logic signed [7:0]  PCT_LIMIT   = 8'sd100;

    // shared multiplier of each lane
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // floor(n / 100) = (n * DIV100_MUL) >> DIV100_SHIFT, exact for n < 2^23
    localparam logic signed [MUL_W-1:0] DIV100_MUL = 25'sd10737419;
    localparam int DIV100_SHIFT = 30;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] ff_gain;
        logic [15:0] speed_per_tick;
        logic [15:0] pwm_top;
    } dwpi_cfg_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic enable;
    } lane_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [7:0]  drive;
        logic [15:0]        leg1;
        logic [15:0]        leg2;
    } lane_res_t;

endpackage

>>> design/dwpi_ifs.sv
// Channel interfaces of the dual wheel PI controller: tick samples in,
// compare/speed results out, register writes. Uses dwpi_pkg.
`timescale 1ns / 1ps

interface dwpi_sample_if;
    import dwpi_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [15:0] ticks_left;
    logic signed [15:0] ticks_right;
    logic signed [15:0] setpoint_left;
    logic signed [15:0] setpoint_right;
    logic               loop_enable;

    modport source (output valid, ticks_left, ticks_right, setpoint_left, setpoint_right,
                    loop_enable, input ready);
    modport sink   (input valid, ticks_left, ticks_right, setpoint_left, setpoint_right,
                    loop_enable, output ready);
endinterface

interface dwpi_result_if;
    import dwpi_pkg::*;
    logic               valid;
    logic               ready;
    logic [15:0]        left_leg1_compare;
    logic [15:0]        left_leg2_compare;
    logic [15:0]        right_leg1_compare;
    logic [15:0]        right_leg2_compare;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;
    logic signed [7:0]  drive_left;
    logic signed [7:0]  drive_right;

    modport source (output valid, left_leg1_compare, left_leg2_compare, right_leg1_compare,
                    right_leg2_compare, speed_left, speed_right, drive_left, drive_right,
                    input ready);
    modport sink   (input valid, left_leg1_compare, left_leg2_compare, right_leg1_compare,
                    right_leg2_compare, speed_left, speed_right, drive_left, drive_right,
                    output ready);
endinterface

interface dwpi_cfg_if;
    import dwpi_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/dwpi_lane.sv
// One wheel lane: speed measurement, incremental PI, feedforward and leg
// compare values, sequenced over a shared 25x25 multiplier. Uses dwpi_pkg.
`timescale 1ns / 1ps

module dwpi_lane
    import dwpi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dwpi_cfg_t          cfg,
    input  lane_ctl_t          ctl,
    input  logic signed [15:0] ticks,
    input  logic signed [15:0] target,
    input  logic               take,
    output lane_stat_t         stat,
    output lane_res_t          res
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MSPD = 4'd1;
    localparam logic [3:0] ST_MFF  = 4'd2;
    localparam logic [3:0] ST_ERR  = 4'd3;
    localparam logic [3:0] ST_MP   = 4'd4;
    localparam logic [3:0] ST_MI   = 4'd5;
    localparam logic [3:0] ST_INT  = 4'd6;
    localparam logic [3:0] ST_DRV  = 4'd7;
    localparam logic [3:0] ST_MTOP = 4'd8;
    localparam logic [3:0] ST_ABS  = 4'd9;
    localparam logic [3:0] ST_MDIV = 4'd10;
    localparam logic [3:0] ST_LEG  = 4'd11;
    localparam logic [3:0] ST_HOLD = 4'd12;

    logic [3:0]                state_reg, state_next;
    logic signed [15:0]        ticks_reg, target_reg;
    logic                      en_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [15:0]        speed_reg, err_reg, prev_reg, integ_reg;
    logic signed [7:0]         ff_reg, drive_reg;
    logic signed [35:0]        pterm_reg;
    logic                      neg_reg;
    logic [22:0]               mag_reg;
    logic [15:0]               leg1_reg, leg2_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_next;

    logic signed [24:0]        spd_raw;
    logic signed [15:0]        spd_sat;
    logic signed [32:0]        ff_prod, ff_adj;
    logic signed [16:0]        ff_q;
    logic signed [7:0]         ff_sat;
    logic signed [16:0]        err_diff, err_step;
    logic signed [15:0]        err_sat;
    logic signed [35:0]        acc;
    logic signed [28:0]        integ_sum;
    logic signed [15:0]        integ_new;
    logic signed [16:0]        drv_sum;
    logic signed [15:0]        drv_clamp, drv_adj;
    logic signed [23:0]        top_prod;
    logic [15:0]               dq;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MSPD:
            begin
                mul_a = MUL_W'(ticks_reg);
                mul_b = MUL_W'($signed({1'b0, cfg.speed_per_tick}));
            end
            ST_MFF:
            begin
                mul_a = MUL_W'(target_reg);
                mul_b = MUL_W'($signed({1'b0, cfg.ff_gain}));
            end
            ST_MP:
            begin
                mul_a = MUL_W'(err_step);
                mul_b = MUL_W'($signed({1'b0, cfg.prop_gain}));
            end
            ST_MI:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'($signed({1'b0, cfg.integ_gain}));
            end
            ST_MTOP:
            begin
                mul_a = MUL_W'(drive_reg);
                mul_b = MUL_W'($signed({1'b0, cfg.pwm_top}));
            end
            ST_MDIV:
            begin
                mul_a = MUL_W'($signed({1'b0, mag_reg}));
                mul_b = DIV100_MUL;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // speed = floor(p / 256), saturated
    assign spd_raw = prod_reg[32:8];
    assign spd_sat = (spd_raw > 25'sd32767)  ? 16'sd32767 :
                     (spd_raw < -25'sd32768) ? -16'sd32768 : spd_raw[15:0];

    // feedforward, truncated toward zero then clamped
    assign ff_prod = prod_reg[32:0];
    assign ff_adj  = ff_prod + (ff_prod[32] ? 33'sd65535 : 33'sd0);
    assign ff_q    = ff_adj[32:16];
    assign ff_sat  = (ff_q > 17'sd100)  ? PCT_LIMIT :
                     (ff_q < -17'sd100) ? -PCT_LIMIT : ff_q[7:0];

    assign err_diff = {target_reg[15], target_reg} - {speed_reg[15], speed_reg};
    assign err_sat  = (err_diff > 17'sd32767)  ? 16'sd32767 :
                      (err_diff < -17'sd32768) ? -16'sd32768 : err_diff[15:0];
    assign err_step = {err_reg[15], err_reg} - {prev_reg[15], prev_reg};

    assign acc       = pterm_reg + prod_reg[35:0];
    assign integ_sum = 29'(acc >>> 8) + 29'(integ_reg);
    assign integ_new = (integ_sum > 29'(PCT_LIMIT_Q))  ? PCT_LIMIT_Q :
                       (integ_sum < -29'(PCT_LIMIT_Q)) ? -PCT_LIMIT_Q : integ_sum[15:0];

    assign drv_sum   = {ff_reg[7], ff_reg, 8'b0} + 17'(integ_reg);
    assign drv_clamp = (drv_sum > 17'(PCT_LIMIT_Q))  ? PCT_LIMIT_Q :
                       (drv_sum < -17'(PCT_LIMIT_Q)) ? -PCT_LIMIT_Q : drv_sum[15:0];
    assign drv_adj   = drv_clamp + (drv_clamp[15] ? 16'sd255 : 16'sd0);

    assign top_prod = prod_reg[23:0];
    assign dq       = prod_reg[DIV100_SHIFT+15:DIV100_SHIFT];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ctl.start) state_next = ST_MSPD;
            ST_MSPD: state_next = ST_MFF;
            ST_MFF:  state_next = ST_ERR;
            ST_ERR:  state_next = ST_MP;
            ST_MP:   state_next = ST_MI;
            ST_MI:   state_next = ST_INT;
            ST_INT:  state_next = ST_DRV;
            ST_DRV:  state_next = ST_MTOP;
            ST_MTOP: state_next = ST_ABS;
            ST_ABS:  state_next = ST_MDIV;
            ST_MDIV: state_next = ST_LEG;
            ST_LEG:  state_next = ST_HOLD;
            ST_HOLD: if (take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && ctl.start && ctl.clear)
            begin
                integ_reg <= '0;
                prev_reg  <= '0;
            end
            else if (state_reg == ST_INT && en_reg)
            begin
                integ_reg <= integ_new;
                prev_reg  <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    ticks_reg  <= ticks;
                    target_reg <= target;
                    en_reg     <= ctl.enable;
                end
            end
            ST_MFF: speed_reg <= spd_sat;
            ST_ERR:
            begin
                ff_reg  <= ff_sat;
                err_reg <= err_sat;
            end
            ST_MI:  pterm_reg <= prod_reg[35:0];
            ST_DRV: drive_reg <= en_reg ? drv_adj[15:8] : 8'sd0;
            ST_ABS:
            begin
                neg_reg <= top_prod[23];
                mag_reg <= top_prod[23] ? 23'(-top_prod) : top_prod[22:0];
            end
            ST_LEG:
            begin
                leg1_reg <= neg_reg ? cfg.pwm_top : cfg.pwm_top - dq;
                leg2_reg <= neg_reg ? cfg.pwm_top - dq : cfg.pwm_top;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_HOLD);
    assign res.speed = speed_reg;
    assign res.drive = drive_reg;
    assign res.leg1  = leg1_reg;
    assign res.leg2  = leg2_reg;

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg >= -PCT_LIMIT_Q && integ_reg <= PCT_LIMIT_Q)
        else $error("integrator outside +-100 percent");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && ctl.start && ctl.clear |=> integ_reg == 0 && prev_reg == 0)
        else $error("enable edge did not clear PI state");

    a_brake: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HOLD && !en_reg |-> drive_reg == 0)
        else $error("nonzero drive while loop disabled");

    a_legs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEG |=> leg1_reg == $past(cfg.pwm_top) || leg2_reg == $past(cfg.pwm_top))
        else $error("neither leg at pwm top");

endmodule

>>> design/dwpi_merge.sv
// Merge stage: joins the two lane results into one output word and holds it
// until the sink takes it. Uses dwpi_pkg and dwpi_result_if.
`timescale 1ns / 1ps

module dwpi_merge
    import dwpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_stat_t            stat_l,
    input  lane_stat_t            stat_r,
    input  lane_res_t             res_l,
    input  lane_res_t             res_r,
    output logic                  take,
    dwpi_result_if.source         result
);

    logic      valid_reg;
    lane_res_t left_reg, right_reg;

    // lanes run in lockstep; load when the output slot is free
    assign take = stat_l.done && stat_r.done && (!valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_reg  <= res_l;
            right_reg <= res_r;
        end
    end

    assign result.valid              = valid_reg;
    assign result.left_leg1_compare  = left_reg.leg1;
    assign result.left_leg2_compare  = left_reg.leg2;
    assign result.right_leg1_compare = right_reg.leg1;
    assign result.right_leg2_compare = right_reg.leg2;
    assign result.speed_left         = left_reg.speed;
    assign result.speed_right        = right_reg.speed;
    assign result.drive_left         = left_reg.drive;
    assign result.drive_right        = right_reg.drive;

endmodule

>>> design/dual_wheel_pi_antiphase_pwm_core.sv
// Top level of the dual wheel PI controller with locked-antiphase outputs.
// Depends on dwpi_pkg, dwpi_ifs, dwpi_lane and dwpi_merge.
//
//   channel   dir   handshake      word
//   sample    in    valid/ready    encoder deltas, targets, loop_enable
//   result    out   valid/ready    four leg compares, speeds, drive percents
//   cfg       in    valid/ready    register index, 16-bit data (ready always high)
//
// Each word is run by the lane sequencer, stepping through six multiplies on its
// one multiplier. A new sample is taken once both lanes have handed their result
// to the output register, so no sample is taken while a word is still in a lane.
// Reset clears the PI state, the enable history and loads register defaults.
// A stalled result holds in the output register; the lanes wait behind it.
`timescale 1ns / 1ps

module dual_wheel_pi_antiphase_pwm_core
    import dwpi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dwpi_sample_if.sink   sample,
    dwpi_result_if.source result,
    dwpi_cfg_if.sink      cfg
);

    dwpi_cfg_t  cfg_reg;
    logic       was_en_reg;
    lane_ctl_t  ctl;
    lane_stat_t stat_l, stat_r;
    lane_res_t  res_l, res_r;
    logic       take;
    logic       accept;

    assign cfg.ready    = 1'b1;
    assign sample.ready = !stat_l.busy && !stat_r.busy;
    assign accept       = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= RST_PROP_GAIN;
            cfg_reg.integ_gain     <= RST_INTEG_GAIN;
            cfg_reg.ff_gain        <= RST_FF_GAIN;
            cfg_reg.speed_per_tick <= RST_SPEED_PER_TICK;
            cfg_reg.pwm_top        <= RST_PWM_TOP;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PROP_GAIN:      cfg_reg.prop_gain      <= cfg.data;
                REG_INTEG_GAIN:     cfg_reg.integ_gain     <= cfg.data;
                REG_FF_GAIN:        cfg_reg.ff_gain        <= cfg.data;
                REG_SPEED_PER_TICK: cfg_reg.speed_per_tick <= cfg.data;
                REG_PWM_TOP:        cfg_reg.pwm_top        <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            was_en_reg <= 1'b0;
        else if (accept)
            was_en_reg <= sample.loop_enable;
    end

    assign ctl.start  = accept;
    assign ctl.enable = sample.loop_enable;
    assign ctl.clear  = sample.loop_enable && !was_en_reg;

    dwpi_lane u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ctl    (ctl),
        .ticks  (sample.ticks_left),
        .target (sample.setpoint_left),
        .take   (take),
        .stat   (stat_l),
        .res    (res_l)
    );

    dwpi_lane u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ctl    (ctl),
        .ticks  (sample.ticks_right),
        .target (sample.setpoint_right),
        .take   (take),
        .stat   (stat_r),
        .res    (res_r)
    );

    dwpi_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .stat_l (stat_l),
        .stat_r (stat_r),
        .res_l  (res_l),
        .res_r  (res_r),
        .take   (take),
        .result (result)
    );

endmodule

>>> verif/dual_wheel_pi_antiphase_pwm_core_tb.sv
// Self-checking testbench for dual_wheel_pi_antiphase_pwm_core: directed and random
// control ticks, per-tick prediction of compares, speeds and drive percents.
// Depends on dwpi_pkg, dwpi_ifs and the core RTL.
`timescale 1ns / 1ps

module dual_wheel_pi_antiphase_pwm_core_tb;
    import dwpi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic signed [15:0] ticks_l;
        logic signed [15:0] ticks_r;
        logic signed [15:0] target_l;
        logic signed [15:0] target_r;
        logic               en;
    } tick_word_t;

    typedef struct {
        logic [15:0]        l1;
        logic [15:0]        l2;
        logic [15:0]        r1;
        logic [15:0]        r2;
        logic signed [15:0] spd_l;
        logic signed [15:0] spd_r;
        logic signed [7:0]  drv_l;
        logic signed [7:0]  drv_r;
    } pwm_word_t;

    logic clk;
    logic rst_n;

    dwpi_sample_if tick_if ();
    dwpi_result_if pwm_if ();
    dwpi_cfg_if    reg_if ();

    dual_wheel_pi_antiphase_pwm_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (tick_if),
        .result (pwm_if),
        .cfg    (reg_if)
    );

    // controller copy: registers and PI state
    logic [15:0] kp_reg;
    logic [15:0] ki_reg;
    logic [15:0] kff_reg;
    logic [15:0] spt_reg;
    logic [15:0] top_reg;
    longint      integ_acc [2];
    longint      err_prev [2];
    logic        enabled_last;

    tick_word_t tick_queue [$];
    pwm_word_t  drive_words_due [$];
    int         pushed_cnt;
    int         accepted_cnt;
    int         fail_cnt;
    bit         idle_on;
    logic       sink_hold;
    bit         en_run;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint limit_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint wheel_speed(logic signed [15:0] ticks);
        longint p;
        p = longint'(ticks) * longint'(spt_reg);
        return limit_to(p >>> 8, -32768, 32767);
    endfunction

    function automatic longint wheel_drive(int w, longint target, longint speed);
        longint err;
        longint inc;
        longint ff;
        longint sum;
        err = limit_to(target - speed, -32768, 32767);
        inc = (longint'(kp_reg) * (err - err_prev[w]) + longint'(ki_reg) * err) >>> 8;
        integ_acc[w] = limit_to(integ_acc[w] + inc, -25600, 25600);
        err_prev[w] = err;
        ff = limit_to((target * longint'(kff_reg)) / 65536, -100, 100);
        sum = limit_to(ff * 256 + integ_acc[w], -25600, 25600);
        return sum / 256;
    endfunction

    // locked antiphase: one leg at top, the other pulled down by the drive share
    function automatic void leg_pair(longint drive, output logic [15:0] leg1,
                                     output logic [15:0] leg2);
        longint top;
        longint delta;
        top = longint'(top_reg);
        delta = (drive * top) / 100;
        if (delta < 0)
        begin
            leg1 = 16'(top);
            leg2 = 16'(top + delta);
        end
        else
        begin
            leg1 = 16'(top - delta);
            leg2 = 16'(top);
        end
    endfunction

    function automatic pwm_word_t run_control_tick(tick_word_t t);
        pwm_word_t w;
        longint    spd_l;
        longint    spd_r;
        longint    drv_l;
        longint    drv_r;
        spd_l = wheel_speed(t.ticks_l);
        spd_r = wheel_speed(t.ticks_r);
        drv_l = 0;
        drv_r = 0;
        if (t.en && !enabled_last)
        begin
            integ_acc = '{0, 0};
            err_prev = '{0, 0};
        end
        enabled_last = t.en;
        if (t.en)
        begin
            drv_l = wheel_drive(0, longint'(t.target_l), spd_l);
            drv_r = wheel_drive(1, longint'(t.target_r), spd_r);
        end
        leg_pair(drv_l, w.l1, w.l2);
        leg_pair(drv_r, w.r1, w.r2);
        w.spd_l = 16'(spd_l);
        w.spd_r = 16'(spd_r);
        w.drv_l = 8'(drv_l);
        w.drv_r = 8'(drv_r);
        return w;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly plausible values around span, sometimes anything in 16 bits
    function automatic logic signed [15:0] pick_value(int span);
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [15:0] pick_reg(int unsigned hi);
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, hi));
    endfunction

    // tick driver
    int unsigned src_gap;
    tick_word_t  cur_tick;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_if.valid && tick_if.ready)
            begin
                drive_words_due.push_back(run_control_tick(cur_tick));
                accepted_cnt++;
            end
            if (!tick_if.valid || tick_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    tick_if.valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    cur_tick = tick_queue.pop_front();
                    tick_if.ticks_left     <= cur_tick.ticks_l;
                    tick_if.ticks_right    <= cur_tick.ticks_r;
                    tick_if.setpoint_left  <= cur_tick.target_l;
                    tick_if.setpoint_right <= cur_tick.target_r;
                    tick_if.loop_enable    <= cur_tick.en;
                    tick_if.valid          <= 1'b1;
                    src_gap = pick_gap();
                end
                else
                    tick_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    int unsigned snk_gap;

    always @(posedge clk)
    begin : result_mon
        pwm_word_t want;
        if (rst_n)
        begin
            if (pwm_if.valid && pwm_if.ready)
            begin
                if (drive_words_due.size() == 0)
                begin
                    $error("result word with nothing outstanding");
                    fail_cnt++;
                end
                else
                begin
                    want = drive_words_due.pop_front();
                    check_field("left_leg1_compare", want.l1, pwm_if.left_leg1_compare);
                    check_field("left_leg2_compare", want.l2, pwm_if.left_leg2_compare);
                    check_field("right_leg1_compare", want.r1, pwm_if.right_leg1_compare);
                    check_field("right_leg2_compare", want.r2, pwm_if.right_leg2_compare);
                    check_field("speed_left", want.spd_l, pwm_if.speed_left);
                    check_field("speed_right", want.spd_r, pwm_if.speed_right);
                    check_field("drive_left", want.drv_l, pwm_if.drive_left);
                    check_field("drive_right", want.drv_r, pwm_if.drive_right);
                end
            end
            if (sink_hold)
                pwm_if.ready <= 1'b0;
            else if (snk_gap > 0)
            begin
                snk_gap--;
                pwm_if.ready <= 1'b0;
            end
            else
            begin
                pwm_if.ready <= 1'b1;
                snk_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    task automatic push_tick(logic signed [15:0] tl, logic signed [15:0] tr,
                             logic signed [15:0] gl, logic signed [15:0] gr, logic en);
        tick_word_t t;
        t.ticks_l = tl;
        t.ticks_r = tr;
        t.target_l = gl;
        t.target_r = gr;
        t.en = en;
        tick_queue.push_back(t);
        pushed_cnt++;
    endtask

    // enable mostly held high in long runs, dropped now and then
    task automatic push_random(int n);
        for (int k = 0; k < n; k++)
        begin
            if (en_run)
                en_run = ($urandom_range(0, 19) != 0);
            else
                en_run = ($urandom_range(0, 2) == 0);
            push_tick(pick_value(300), pick_value(300), pick_value(9000),
                      pick_value(9000), en_run);
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (accepted_cnt != pushed_cnt || drive_words_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        reg_if.index <= idx;
        reg_if.data  <= val;
        reg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!reg_if.ready);
        reg_if.valid <= 1'b0;
        case (idx)
            REG_PROP_GAIN:      kp_reg = val;
            REG_INTEG_GAIN:     ki_reg = val;
            REG_FF_GAIN:        kff_reg = val;
            REG_SPEED_PER_TICK: spt_reg = val;
            REG_PWM_TOP:        top_reg = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] kp, logic [15:0] ki, logic [15:0] kff,
                             logic [15:0] spt, logic [15:0] top);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_FF_GAIN, kff);
        write_reg(REG_SPEED_PER_TICK, spt);
        write_reg(REG_PWM_TOP, top);
    endtask

    initial
    begin
        #(8_000_000);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        tick_if.valid = 1'b0;
        tick_if.ticks_left = '0;
        tick_if.ticks_right = '0;
        tick_if.setpoint_left = '0;
        tick_if.setpoint_right = '0;
        tick_if.loop_enable = 1'b0;
        pwm_if.ready = 1'b0;
        reg_if.valid = 1'b0;
        reg_if.index = '0;
        reg_if.data = '0;
        sink_hold = 1'b0;
        idle_on = 1'b1;
        en_run = 1'b1;
        src_gap = 0;
        snk_gap = 0;
        pushed_cnt = 0;
        accepted_cnt = 0;
        fail_cnt = 0;
        kp_reg = RST_PROP_GAIN;
        ki_reg = RST_INTEG_GAIN;
        kff_reg = RST_FF_GAIN;
        spt_reg = RST_SPEED_PER_TICK;
        top_reg = RST_PWM_TOP;
        integ_acc = '{0, 0};
        err_prev = '{0, 0};
        enabled_last = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: brake, enable edges, saturation of speed, error and feedforward
        push_tick(0, 0, 0, 0, 0);
        push_tick(100, -100, 5000, -5000, 0);
        push_tick(0, 0, 0, 0, 1);
        push_tick(10, 10, 2560, 2560, 1);
        push_tick(20, -20, 2560, -2560, 1);
        push_tick(16'sh7fff, 16'sh8000, 0, 0, 1);
        push_tick(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1);
        push_tick(0, 0, 16'sh7fff, 16'sh8000, 1);
        push_tick(0, 0, 16'sh7fff, 16'sh8000, 1);
        push_tick(0, 0, 16'sh8000, 16'sh7fff, 1);
        push_tick(5, 5, 1000, 1000, 0);
        push_tick(5, 5, 1000, 1000, 1);
        push_tick(1, -1, 1, -1, 1);
        push_tick(-1, 1, -1, 1, 1);
        push_tick(0, 0, -1, 1, 1);
        push_tick(12, -7, 4000, -300, 1);
        push_tick(12, -7, 4000, -300, 1);
        push_tick(-3, 3, 16'sh8000, 16'sh7fff, 0);
        wait_idle();

        // back to back, no idling
        idle_on = 1'b0;
        push_random(160);
        wait_idle();
        idle_on = 1'b1;
        push_random(300);
        wait_idle();

        // everything at zero, including a zero timer period; spare indexes ignored
        write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        write_reg(REG_SPARE_LO, 16'hffff);
        write_reg(REG_SPARE_HI, 16'($urandom));
        push_random(80);
        wait_idle();

        write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        write_reg(REG_SPARE_HI, 16'h0000);
        push_random(120);
        wait_idle();

        for (int k = 0; k < 3; k++)
        begin
            write_all(pick_reg(2048), pick_reg(512), pick_reg(2048), pick_reg(40000),
                      pick_reg(2000));
            push_random(150);
            wait_idle();
        end

        // output held off long enough for the core to back up onto its input
        write_all(RST_PROP_GAIN, RST_INTEG_GAIN, RST_FF_GAIN, RST_SPEED_PER_TICK,
                  RST_PWM_TOP);
        idle_on = 1'b0;
        fork
            begin
                @(posedge clk);
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        push_random(80);
        wait_idle();
        idle_on = 1'b1;
        push_random(80);
        wait_idle();

        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
